FILE: sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define FCSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define FCSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fcsd_pkg.sv
// Shared types and constants of the frame check and SET decode block.
package fcsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 7;
  localparam int unsigned PosW    = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned GainW   = 29;
  localparam int unsigned RateW   = 15;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndCode   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSetCmd    = 2'd2;

  // Configuration reset values.
  localparam logic [ByteW-1:0] StartCodeRst = 8'h82;
  localparam logic [ByteW-1:0] EndCodeRst   = 8'h83;
  localparam logic [CmdW-1:0]  SetCmdRst    = 7'd1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatSetOk    = 3'd0;
  localparam logic [StatusW-1:0] StatOtherOk  = 3'd1;
  localparam logic [StatusW-1:0] StatTooShort = 3'd2;
  localparam logic [StatusW-1:0] StatBadSum   = 3'd3;
  localparam logic [StatusW-1:0] StatSetShort = 3'd4;

  // Frame layout, counted in data bytes after the start code.
  localparam int unsigned HdrCmdPos = 0;
  localparam int unsigned HdrLenPos = 2;
  localparam int unsigned PayFirst  = 3;
  localparam int unsigned PayDepth  = 11;
  // Shortest frame is 7 bytes including start and end code.
  localparam int unsigned MinPos    = 5;

  localparam logic [ByteW-1:0] FlagOn = 8'h02;
  localparam int unsigned GainSh3 = 21;
  localparam int unsigned GainSh2 = 14;
  localparam int unsigned GainSh1 = 7;
  localparam int unsigned RateSh  = 7;

  typedef struct packed {
    logic                           close;
    logic [PosW-1:0]                position;
    logic [SumW-1:0]                sum;
    logic [ByteW-1:0]               recent0;
    logic [ByteW-1:0]               recent1;
    logic [ByteW-1:0]               cmd;
    logic [ByteW-1:0]               len;
    logic [PayDepth-1:0][ByteW-1:0] pay;
  } frame_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   command;
    logic               second_channel;
    logic               sinc4_filter;
    logic               chop_enable;
    logic               delay_disable;
    logic               reject60;
    logic [GainW-1:0]   gain_value;
    logic [RateW-1:0]   sample_rate;
  } result_t;

endpackage

FILE: sv/fcsd_frame.sv
// Frame tracker: position, running sum, last two data bytes and stored frame bytes.
module fcsd_frame (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [fcsd_pkg::ByteW-1:0]      byte_i,
  input  logic [fcsd_pkg::ByteW-1:0]      open_code_i,
  input  logic [fcsd_pkg::ByteW-1:0]      close_code_i,
  output fcsd_pkg::frame_t                frame_o
);
  import fcsd_pkg::*;

  logic                           in_frame_q;
  logic [PosW-1:0]                pos_q;
  logic [SumW-1:0]                sum_q;
  logic [ByteW-1:0]               rec0_q, rec1_q;
  logic [ByteW-1:0]               hdr_cmd_q, hdr_len_q;
  logic [PayDepth-1:0][ByteW-1:0] pay_q;
  logic [PayDepth-1:0][ByteW-1:0] pay_view;
  logic                           is_start, is_end, wr;

  assign is_start = (byte_i == open_code_i);
  assign is_end   = (byte_i == close_code_i);
  assign wr       = en_i & ~is_start & in_frame_q;

  // The decoder sees the payload with this byte already written, since the
  // end code itself may land in a payload slot.
  always_comb begin
    for (int k = 0; k < PayDepth; k++) begin
      pay_view[k] = (wr && pos_q == PosW'(PayFirst + k)) ? byte_i : pay_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
      rec0_q     <= '0;
      rec1_q     <= '0;
    end else if (en_i) begin
      if (is_start) begin
        in_frame_q <= 1'b1;
        pos_q      <= '0;
        sum_q      <= '0;
        rec0_q     <= '0;
        rec1_q     <= '0;
      end else if (in_frame_q) begin
        if (is_end) begin
          in_frame_q <= 1'b0;
        end else begin
          // The two latest bytes are held back: they may be the checksum.
          sum_q  <= sum_q + SumW'(rec1_q);
          rec1_q <= rec0_q;
          rec0_q <= byte_i;
          if (pos_q != '1) begin
            pos_q <= pos_q + PosW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      if (pos_q == PosW'(HdrCmdPos)) begin
        hdr_cmd_q <= byte_i;
      end
      if (pos_q == PosW'(HdrLenPos)) begin
        hdr_len_q <= byte_i;
      end
    end
    pay_q <= pay_view;
  end

  always_comb begin
    frame_o          = '0;
    frame_o.close    = wr & is_end;
    frame_o.position = pos_q;
    frame_o.sum      = sum_q;
    frame_o.recent0  = rec0_q;
    frame_o.recent1  = rec1_q;
    frame_o.cmd      = hdr_cmd_q;
    frame_o.len      = hdr_len_q;
    frame_o.pay      = pay_view;
  end

endmodule

FILE: sv/fcsd_decode.sv
// Frame checker and SET decoder with the stored sample rate.
module fcsd_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  fcsd_pkg::frame_t           frame_i,
  input  logic [fcsd_pkg::CmdW-1:0]  set_command_i,
  output fcsd_pkg::result_t          res_o
);
  import fcsd_pkg::*;

  logic [RateW-1:0] rate_q;
  logic [SumW-1:0]  inv;
  logic [RateW-1:0] fs;
  logic             rate_upd;

  assign inv = ~frame_i.sum;
  assign fs  = (RateW'(frame_i.pay[9]) << RateSh) | RateW'(frame_i.pay[10]);

  always_comb begin
    res_o    = '0;
    rate_upd = 1'b0;
    if (frame_i.position < PosW'(MinPos)) begin
      res_o.status = StatTooShort;
    end else if (frame_i.recent1 != {1'b0, inv[14:8]} ||
                 frame_i.recent0 != {1'b0, inv[6:0]}) begin
      res_o.status = StatBadSum;
    end else begin
      res_o.command = frame_i.cmd;
      if (frame_i.cmd != {1'b0, set_command_i}) begin
        res_o.status = StatOtherOk;
      end else if (frame_i.len < ByteW'(PayDepth)) begin
        res_o.status = StatSetShort;
      end else begin
        res_o.status         = StatSetOk;
        res_o.second_channel = (frame_i.pay[0] == FlagOn);
        res_o.sinc4_filter   = (frame_i.pay[1] == FlagOn);
        res_o.chop_enable    = (frame_i.pay[2] == FlagOn);
        res_o.delay_disable  = (frame_i.pay[3] == FlagOn);
        res_o.reject60       = (frame_i.pay[4] == FlagOn);
        res_o.gain_value     = (GainW'(frame_i.pay[5]) << GainSh3) |
                               (GainW'(frame_i.pay[6]) << GainSh2) |
                               (GainW'(frame_i.pay[7]) << GainSh1) |
                               GainW'(frame_i.pay[8]);
        rate_upd             = (fs != '0);
      end
    end
    res_o.sample_rate = rate_upd ? fs : rate_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (upd_i && rate_upd) begin
      rate_q <= fs;
    end
  end

endmodule

FILE: sv/frame_check_and_set_decode.sv
// Top level: input register, frame tracker, decoder and result register.
// A result follows the transfer of the end code byte through the input register
// and the result register. Throughput: one byte per cycle unless the output
// stalls; the input register and the result register let a new byte be taken
// while a result waits on a stalled output.
// Reset clears the frame state, the stored rate and both valid flags, and sets
// the start code, end code and SET command registers to their defaults.
module frame_check_and_set_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fcsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fcsd_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fcsd_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fcsd_pkg::StatusW-1:0]  status_o,
  output logic [fcsd_pkg::ByteW-1:0]    command_o,
  output logic                          second_channel_o,
  output logic                          sinc4_filter_o,
  output logic                          chop_enable_o,
  output logic                          delay_disable_o,
  output logic                          reject60_o,
  output logic [fcsd_pkg::GainW-1:0]    gain_value_o,
  output logic [fcsd_pkg::RateW-1:0]    sample_rate_o
);
  import fcsd_pkg::*;

  logic [ByteW-1:0] open_code_q, close_code_q;
  logic [CmdW-1:0]  set_cmd_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          res_q;
  frame_t           frame;
  result_t          res;
  logic             advance, step, emit;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & advance;
  assign emit       = step & frame.close;
  assign in_stall_o = in_valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_code_q  <= StartCodeRst;
      close_code_q <= EndCodeRst;
      set_cmd_q    <= SetCmdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartCode: open_code_q  <= cfg_data_i;
        CfgEndCode:   close_code_q <= cfg_data_i;
        CfgSetCmd:    set_cmd_q    <= cfg_data_i[CmdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (emit) begin
      res_q <= res;
    end
  end

  fcsd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (step),
    .byte_i       (in_byte_q),
    .open_code_i  (open_code_q),
    .close_code_i (close_code_q),
    .frame_o      (frame)
  );

  fcsd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (emit),
    .frame_i       (frame),
    .set_command_i (set_cmd_q),
    .res_o         (res)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign command_o        = res_q.command;
  assign second_channel_o = res_q.second_channel;
  assign sinc4_filter_o   = res_q.sinc4_filter;
  assign chop_enable_o    = res_q.chop_enable;
  assign delay_disable_o  = res_q.delay_disable;
  assign reject60_o       = res_q.reject60;
  assign gain_value_o     = res_q.gain_value;
  assign sample_rate_o    = res_q.sample_rate;

endmodule

FILE: sv/fcsd_checker.sv
// Port-level checker for the frame check and SET decode block, with its bind.
`include "assert_macros.svh"

module fcsd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [fcsd_pkg::StatusW-1:0]  status_o,
  input  logic [fcsd_pkg::ByteW-1:0]    command_o,
  input  logic                          second_channel_o,
  input  logic                          sinc4_filter_o,
  input  logic                          chop_enable_o,
  input  logic                          delay_disable_o,
  input  logic                          reject60_o,
  input  logic [fcsd_pkg::GainW-1:0]    gain_value_o
);
  import fcsd_pkg::*;

  // A stalled result stays presented with the same status.
  `FCSD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o), "stalled result changed")

  // Only a successful SET frame carries decoded settings.
  `FCSD_ASSERT(a_no_settings, clk_i, rst_ni, out_valid_o && status_o != StatSetOk |-> gain_value_o == '0 && !second_channel_o && !sinc4_filter_o && !chop_enable_o && !delay_disable_o && !reject60_o, "settings on a failed frame")

  // Rejected frames report no command byte.
  `FCSD_ASSERT(a_err_cmd, clk_i, rst_ni, out_valid_o && (status_o == StatTooShort || status_o == StatBadSum) |-> command_o == '0, "command on a rejected frame")

  // A new result is caused by an earlier byte transfer on the input.
  `FCSD_ASSERT(a_out_cause, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "result without a transfer")

  // No result is presented right after reset.
  `FCSD_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind frame_check_and_set_decode fcsd_checker u_fcsd_checker (.*);

FILE: sim/frame_check_and_set_decode_tb.sv
// Self-checking testbench for the frame check and SET decode block.
module frame_check_and_set_decode_tb;
  import fcsd_pkg::*;

  typedef logic [ByteW-1:0] octet_t;
  typedef enum int {FillRandom, FillMax, FillZero} fill_e;

  localparam int unsigned CycleLimit = 400000;
  localparam octet_t OtherCmd = 8'h05;

  // Tracks the link stream as the block should and holds the decodes still to come.
  class frame_scoreboard;
    octet_t           open_code;
    octet_t           close_code;
    logic [CmdW-1:0]  set_cmd;
    bit               in_frame;
    logic [PosW-1:0]  position;
    logic [SumW-1:0]  byte_sum;
    octet_t           recent [2];
    octet_t           header [2];
    octet_t           payload [PayDepth];
    logic [RateW-1:0] stored_rate;
    result_t          decode_q [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      status_count [5];

    function new();
      open_code   = StartCodeRst;
      close_code  = EndCodeRst;
      set_cmd     = SetCmdRst;
      in_frame    = 0;
      position    = '0;
      byte_sum    = '0;
      recent[0]   = '0;
      recent[1]   = '0;
      stored_rate = '0;
      errors      = 0;
      checked     = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, octet_t val);
      case (idx)
        CfgStartCode: open_code = val;
        CfgEndCode:   close_code = val;
        CfgSetCmd:    set_cmd = val[CmdW-1:0];
        default: ;
      endcase
    endfunction

    function void store_byte(octet_t b);
      if (position == PosW'(HdrCmdPos)) header[0] = b;
      else if (position == PosW'(HdrLenPos)) header[1] = b;
      else if (position >= PosW'(PayFirst) && position < PosW'(PayFirst + PayDepth))
        payload[position - PosW'(PayFirst)] = b;
    endfunction

    function void note_byte(octet_t b);
      result_t          r;
      logic [SumW-1:0]  inv;
      logic [31:0]      gain;
      logic [15:0]      rate;
      if (b == open_code) begin
        in_frame  = 1;
        position  = '0;
        byte_sum  = '0;
        recent[0] = '0;
        recent[1] = '0;
        return;
      end
      if (!in_frame) return;
      store_byte(b);
      if (b != close_code) begin
        byte_sum  = byte_sum + SumW'(recent[1]);
        recent[1] = recent[0];
        recent[0] = b;
        if (position != 8'hff) position = position + PosW'(1);
        return;
      end
      in_frame = 0;
      r = '0;
      if (position < PosW'(MinPos)) begin
        r.status = StatTooShort;
      end else begin
        inv = ~byte_sum;
        if (recent[1] != {1'b0, inv[14:8]} || recent[0] != {1'b0, inv[6:0]}) begin
          r.status = StatBadSum;
        end else begin
          r.command = header[0];
          if (header[0] != {1'b0, set_cmd}) begin
            r.status = StatOtherOk;
          end else if (header[1] < ByteW'(PayDepth)) begin
            r.status = StatSetShort;
          end else begin
            r.status         = StatSetOk;
            r.second_channel = (payload[0] == FlagOn);
            r.sinc4_filter   = (payload[1] == FlagOn);
            r.chop_enable    = (payload[2] == FlagOn);
            r.delay_disable  = (payload[3] == FlagOn);
            r.reject60       = (payload[4] == FlagOn);
            gain = (32'(payload[5]) << GainSh3) | (32'(payload[6]) << GainSh2) |
                   (32'(payload[7]) << GainSh1) | 32'(payload[8]);
            r.gain_value = gain[GainW-1:0];
            rate = (16'(payload[9]) << RateSh) | 16'(payload[10]);
            if (rate[RateW-1:0] != '0) stored_rate = rate[RateW-1:0];
          end
        end
      end
      r.sample_rate = stored_rate;
      decode_q.push_back(r);
      status_count[r.status]++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (decode_q.size() == 0) begin
        $display("%0t: result with no frame closed, status %0d command 0x%0h",
                 $time, got.status, got.command);
        errors++;
        return;
      end
      want = decode_q.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("command", 32'(want.command), 32'(got.command));
      compare_field("second_channel", 32'(want.second_channel), 32'(got.second_channel));
      compare_field("sinc4_filter", 32'(want.sinc4_filter), 32'(got.sinc4_filter));
      compare_field("chop_enable", 32'(want.chop_enable), 32'(got.chop_enable));
      compare_field("delay_disable", 32'(want.delay_disable), 32'(got.delay_disable));
      compare_field("reject60", 32'(want.reject60), 32'(got.reject60));
      compare_field("gain_value", 32'(want.gain_value), 32'(got.gain_value));
      compare_field("sample_rate", 32'(want.sample_rate), 32'(got.sample_rate));
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  octet_t             cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  octet_t             rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  octet_t             command;
  logic               second_channel, sinc4_filter, chop_enable, delay_disable, reject60;
  logic [GainW-1:0]   gain_value;
  logic [RateW-1:0]   sample_rate;

  frame_scoreboard sb = new();
  octet_t          frame_q [$];
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     settings_used = 1;
  int              send_mode = 0;
  int              stall_mode = 0;
  int              stall_left = 0;

  frame_check_and_set_decode dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .command_o        (command),
    .second_channel_o (second_channel),
    .sinc4_filter_o   (sinc4_filter),
    .chop_enable_o    (chop_enable),
    .delay_disable_o  (delay_disable),
    .reject60_o       (reject60),
    .gain_value_o     (gain_value),
    .sample_rate_o    (sample_rate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[frame_check_and_set_decode] ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0 || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_mode != 0 && $urandom_range(0, 99) < 30 * stall_mode) begin
      stall_left <= pick_gap(1);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status         = status;
      got.command        = command;
      got.second_channel = second_channel;
      got.sinc4_filter   = sinc4_filter;
      got.chop_enable    = chop_enable;
      got.delay_disable  = delay_disable;
      got.reject60       = reject60;
      got.gain_value     = gain_value;
      got.sample_rate    = sample_rate;
      sb.check_result(got);
    end
  end

  task automatic send_byte(input octet_t b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    gap = pick_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every decode has come out and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.decode_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_codes(input octet_t start_val, input octet_t end_val, input octet_t cmd_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CfgStartCode;
    cfg_data  <= start_val;
    @(posedge clk);
    sb.write_register(CfgStartCode, start_val);
    cfg_index <= CfgEndCode;
    cfg_data  <= end_val;
    @(posedge clk);
    sb.write_register(CfgEndCode, end_val);
    cfg_index <= CfgSetCmd;
    cfg_data  <= cmd_val;
    @(posedge clk);
    sb.write_register(CfgSetCmd, cmd_val);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic octet_t pay_byte(fill_e fill, int idx);
    if (fill == FillZero) return 8'h00;
    if (fill == FillMax) return (idx < 5) ? FlagOn : 8'hff;
    if (idx < 5 && $urandom_range(0, 1) == 0) return FlagOn;
    if ((idx == 9 || idx == 10) && $urandom_range(0, 4) == 0) return 8'h00;
    return octet_t'($urandom);
  endfunction

  // Builds the data bytes of a frame with a correct checksum. The spare byte is
  // redrawn until no byte collides with the framing codes, for at most 20 tries.
  task automatic build_frame(input octet_t cmd, input octet_t len, input int n_pay,
                             input fill_e fill);
    octet_t          pay [$];
    logic [SumW-1:0] acc;
    bit              clash;
    int              tries;
    for (int i = 0; i < n_pay; i++) pay.push_back(pay_byte(fill, i));
    tries = 0;
    do begin
      frame_q.delete();
      frame_q.push_back(cmd);
      frame_q.push_back(octet_t'($urandom));
      frame_q.push_back(len);
      foreach (pay[i]) frame_q.push_back(pay[i]);
      acc = '0;
      foreach (frame_q[i]) acc = acc + SumW'(frame_q[i]);
      frame_q.push_back({1'b0, ~acc[14:8]});
      frame_q.push_back({1'b0, ~acc[6:0]});
      clash = 0;
      foreach (frame_q[i])
        if (frame_q[i] == sb.open_code || frame_q[i] == sb.close_code) clash = 1;
      tries++;
    end while (clash && tries < 20);
  endtask

  task automatic make_random_frame();
    octet_t cmd;
    octet_t len;
    int     n_pay;
    int     roll;
    cmd = ($urandom_range(0, 99) < 60) ? {1'b0, sb.set_cmd} : octet_t'($urandom);
    len = ($urandom_range(0, 99) < 70) ? octet_t'($urandom_range(11, 255))
                                       : octet_t'($urandom_range(0, 10));
    roll = $urandom_range(0, 99);
    if (roll < 80) n_pay = $urandom_range(0, 14);
    else if (roll < 97) n_pay = $urandom_range(15, 40);
    else n_pay = $urandom_range(250, 300);
    build_frame(cmd, len, n_pay, FillRandom);
  endtask

  task automatic send_frame();
    send_byte(sb.open_code);
    foreach (frame_q[i]) send_byte(frame_q[i]);
    send_byte(sb.close_code);
  endtask

  initial begin
    int roll;
    int keep;
    int pos;
    int bit_pos;
    int unsigned next_phase;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings. Bytes outside a frame are ignored.
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(sb.close_code);
    // A full-length SET frame first, so every payload entry holds a written byte.
    build_frame({1'b0, SetCmdRst}, 8'd11, PayDepth, FillMax);
    send_frame();
    build_frame({1'b0, SetCmdRst}, 8'hff, PayDepth, FillZero);
    send_frame();
    build_frame({1'b0, SetCmdRst}, 8'd10, PayDepth, FillRandom);
    send_frame();
    build_frame(OtherCmd, 8'd2, 2, FillRandom);
    send_frame();
    // Command byte with its top bit set must not match the SET command.
    build_frame({1'b1, SetCmdRst}, 8'd11, PayDepth, FillRandom);
    send_frame();
    // Shortest legal frame; the SET decode reads payload left by earlier frames.
    build_frame({1'b0, SetCmdRst}, 8'd11, 0, FillRandom);
    send_frame();
    send_byte(sb.close_code);
    // Frames that are too short.
    send_byte(sb.open_code);
    send_byte(sb.close_code);
    send_byte(sb.open_code);
    for (int i = 0; i < 4; i++) send_byte(octet_t'(i + 1));
    send_byte(sb.close_code);
    // Bad checksum through the top bit of the last checksum byte.
    build_frame({1'b0, SetCmdRst}, 8'd11, PayDepth, FillRandom);
    frame_q[frame_q.size() - 1][7] = 1'b1;
    send_frame();
    // A start code inside a frame restarts it.
    send_byte(sb.open_code);
    send_byte(8'h40);
    send_byte(8'h00);
    send_byte(8'h0b);
    build_frame(OtherCmd, 8'd20, 6, FillRandom);
    send_frame();
    // A frame long enough to saturate the position counter.
    build_frame(OtherCmd, 8'hff, 300, FillRandom);
    send_frame();

    // Extremes of the codes, the set command written with its unused top bit.
    send_mode  = 1;
    stall_mode = 1;
    set_codes(8'h00, 8'hff, 8'h7f);
    for (int i = 0; i < 4; i++) begin
      make_random_frame();
      send_frame();
    end
    set_codes(8'hff, 8'h00, 8'h80);
    for (int i = 0; i < 4; i++) begin
      make_random_frame();
      send_frame();
    end
    // Start and end code equal: the start meaning wins, so no frame ever closes.
    set_codes(8'h55, 8'h55, 8'h01);
    make_random_frame();
    send_frame();
    send_byte(8'h83);

    // Random part: mostly well-formed frames, with noise and broken frames mixed in.
    next_phase = bytes_sent;
    while (bytes_sent < 1000) begin
      if (bytes_sent >= next_phase) begin
        send_mode  = $urandom_range(0, 2);
        stall_mode = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
          roll = $urandom_range(0, 255);
          set_codes(octet_t'(roll), octet_t'(roll), octet_t'($urandom));
        end else begin
          do roll = $urandom_range(0, 255);
          while (roll == 8'h83);
          if ($urandom_range(0, 1) == 0) set_codes(8'h82, 8'h83, octet_t'($urandom));
          else set_codes(octet_t'(roll), 8'h83, octet_t'($urandom));
        end
        next_phase = bytes_sent + 250;
      end
      roll = $urandom_range(0, 99);
      make_random_frame();
      if (roll < 60) begin
        send_frame();
      end else if (roll < 72) begin
        pos     = $urandom_range(0, frame_q.size() - 1);
        bit_pos = $urandom_range(0, 7);
        frame_q[pos][bit_pos] = ~frame_q[pos][bit_pos];
        send_frame();
      end else if (roll < 80) begin
        keep = $urandom_range(0, 4);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
        send_frame();
      end else if (roll < 88) begin
        keep = $urandom_range(1, 8);
        for (int i = 0; i < keep; i++) begin
          case ($urandom_range(0, 5))
            0: send_byte(sb.open_code);
            1: send_byte(sb.close_code);
            default: send_byte(octet_t'($urandom));
          endcase
        end
      end else if (roll < 94) begin
        send_byte(sb.open_code);
        keep = $urandom_range(1, 12);
        for (int i = 0; i < keep && i < frame_q.size(); i++) send_byte(frame_q[i]);
        send_frame();
      end else begin
        // Hold the sender back until every decode has come out.
        drain();
        send_frame();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d link bytes under %0d code settings; checked %0d decodes.",
             bytes_sent, settings_used, sb.checked);
    $display("Decodes seen: set ok %0d, other ok %0d, too short %0d, bad sum %0d, set short %0d.",
             sb.status_count[StatSetOk], sb.status_count[StatOtherOk],
             sb.status_count[StatTooShort], sb.status_count[StatBadSum],
             sb.status_count[StatSetShort]);
    if (sb.errors == 0 && sb.decode_q.size() == 0) begin
      $display("[frame_check_and_set_decode] OK");
    end else begin
      $display("[frame_check_and_set_decode] ERROR");
    end
    $finish;
  end

endmodule
